### rtl/core/ubxfr_pkg.sv
package ubxfr_pkg;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [1:0] CFG_SYNC_FIRST = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_ACK_CLASS = 2'd2;
    localparam logic [1:0] CFG_ACK_POS_ID = 2'd3;

    localparam logic [7:0] RST_SYNC_FIRST = 8'd181;
    localparam logic [7:0] RST_SYNC_SECOND = 8'd98;
    localparam logic [7:0] RST_ACK_CLASS = 8'd5;
    localparam logic [7:0] RST_ACK_POS_ID = 8'd1;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 104;

    localparam logic [15:0] ACK_FRAME_LEN = 16'd2;
    localparam logic [7:0] PENDING_MAX = 8'd255;

    // Parser phases
    localparam logic [3:0] PH_SYNC1 = 4'd0;
    localparam logic [3:0] PH_SYNC2 = 4'd1;
    localparam logic [3:0] PH_CLASS = 4'd2;
    localparam logic [3:0] PH_ID = 4'd3;
    localparam logic [3:0] PH_LEN1 = 4'd4;
    localparam logic [3:0] PH_LEN2 = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CKA = 4'd7;
    localparam logic [3:0] PH_CKB = 4'd8;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] ack_class;
        logic [7:0] ack_pos_id;
    } t_cfg;

    typedef struct packed {
        logic        byte_ok;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic        frame_done;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic        ack_seen;
        logic        ack_positive;
        logic [7:0]  pending_sends;
        logic [31:0] error_count;
    } t_result;

endpackage

### rtl/core/ubxfr_cfg.sv
module ubxfr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ubxfr_pkg::PADDR_W-1:0] paddr,
    input  logic [ubxfr_pkg::PDATA_W-1:0] pwdata,
    output logic [ubxfr_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output ubxfr_pkg::t_cfg               o_cfg
);
    import ubxfr_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= RST_SYNC_FIRST;
            r_cfg.sync_second <= RST_SYNC_SECOND;
            r_cfg.ack_class   <= RST_ACK_CLASS;
            r_cfg.ack_pos_id  <= RST_ACK_POS_ID;
        end else if (w_wr) begin
            unique case (w_idx)
                CFG_SYNC_FIRST:  r_cfg.sync_first  <= pwdata[7:0];
                CFG_SYNC_SECOND: r_cfg.sync_second <= pwdata[7:0];
                CFG_ACK_CLASS:   r_cfg.ack_class   <= pwdata[7:0];
                CFG_ACK_POS_ID:  r_cfg.ack_pos_id  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            CFG_SYNC_FIRST:  prdata[7:0] = r_cfg.sync_first;
            CFG_SYNC_SECOND: prdata[7:0] = r_cfg.sync_second;
            CFG_ACK_CLASS:   prdata[7:0] = r_cfg.ack_class;
            CFG_ACK_POS_ID:  prdata[7:0] = r_cfg.ack_pos_id;
            default:         prdata = '0;
        endcase
    end

endmodule

### rtl/core/ubxfr_parser.sv
module ubxfr_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_action,
    input  logic [7:0]           i_byte,
    input  ubxfr_pkg::t_cfg      i_cfg,
    output ubxfr_pkg::t_result   o_result
);
    import ubxfr_pkg::*;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_taken, n_taken;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_pending, n_pending;
    logic [31:0] r_errors, n_errors;

    logic [7:0]  w_add_a;
    logic [7:0]  w_add_b;
    logic [15:0] w_taken_inc;
    logic [15:0] w_len_full;
    logic        ok;
    t_result     res;

    assign w_add_a     = r_sum_a + i_byte;
    assign w_add_b     = r_sum_b + w_add_a;
    assign w_taken_inc = r_taken + 16'd1;
    assign w_len_full  = {i_byte, r_len[7:0]};

    always_comb begin
        n_phase   = r_phase;
        n_class   = r_class;
        n_id      = r_id;
        n_len     = r_len;
        n_taken   = r_taken;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_pending = r_pending;
        n_errors  = r_errors;
        ok        = 1'b1;
        res       = '0;

        if (i_action) begin
            if (r_pending != PENDING_MAX) n_pending = r_pending + 8'd1;
        end else begin
            unique case (r_phase)
                PH_SYNC1: begin
                    if (i_byte == i_cfg.sync_first) n_phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    if (i_byte == i_cfg.sync_second) n_phase = PH_CLASS;
                    else ok = 1'b0;
                end
                PH_CLASS: begin
                    n_class = i_byte;
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_phase = PH_ID;
                end
                PH_ID: begin
                    n_id    = i_byte;
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_phase = PH_LEN1;
                end
                PH_LEN1: begin
                    n_len   = {8'd0, i_byte};
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_phase = PH_LEN2;
                end
                PH_LEN2: begin
                    n_len   = w_len_full;
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_phase = (w_len_full != 16'd0) ? PH_PAYLOAD : PH_CKA;
                end
                PH_PAYLOAD: begin
                    res.payload_valid  = 1'b1;
                    res.payload_byte   = i_byte;
                    res.payload_offset = r_taken;
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_taken = w_taken_inc;
                    // a wrapped count reads as zero, so keep taking payload then
                    if (w_taken_inc >= r_len) n_phase = PH_CKA;
                end
                PH_CKA: begin
                    if (i_byte == r_sum_a) n_phase = PH_CKB;
                    else ok = 1'b0;
                end
                PH_CKB: begin
                    if (i_byte == r_sum_b) begin
                        res.frame_done     = 1'b1;
                        res.msg_class      = r_class;
                        res.msg_id         = r_id;
                        res.payload_length = r_len;
                        if (r_class == i_cfg.ack_class && r_len == ACK_FRAME_LEN
                            && r_pending != 8'd0) begin
                            n_pending        = r_pending - 8'd1;
                            res.ack_seen     = 1'b1;
                            res.ack_positive = (r_id == i_cfg.ack_pos_id);
                        end
                        n_phase = PH_SYNC1;
                        n_class = '0;
                        n_id    = '0;
                        n_len   = '0;
                        n_taken = '0;
                        n_sum_a = '0;
                        n_sum_b = '0;
                    end else begin
                        ok = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_SYNC1;
                    n_class = '0;
                    n_id    = '0;
                    n_len   = '0;
                    n_taken = '0;
                    n_sum_a = '0;
                    n_sum_b = '0;
                end
            endcase

            // drop the frame, count the error, forget outstanding sends
            if (!ok) begin
                n_errors  = r_errors + 32'd1;
                n_phase   = PH_SYNC1;
                n_class   = '0;
                n_id      = '0;
                n_len     = '0;
                n_taken   = '0;
                n_sum_a   = '0;
                n_sum_b   = '0;
                n_pending = '0;
            end
        end

        res.byte_ok       = ok;
        res.pending_sends = n_pending;
        res.error_count   = n_errors;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC1;
            r_class   <= '0;
            r_id      <= '0;
            r_len     <= '0;
            r_taken   <= '0;
            r_sum_a   <= '0;
            r_sum_b   <= '0;
            r_pending <= '0;
            r_errors  <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_class   <= n_class;
            r_id      <= n_id;
            r_len     <= n_len;
            r_taken   <= n_taken;
            r_sum_a   <= n_sum_a;
            r_sum_b   <= n_sum_b;
            r_pending <= n_pending;
            r_errors  <= n_errors;
        end
    end

endmodule

### rtl/core/ubxfr_out_reg.sv
module ubxfr_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ubxfr_pkg::t_result   i_result,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic                 o_free,
    output ubxfr_pkg::t_result   o_result
);
    import ubxfr_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or being drained this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/core/ubx_frame_receiver.sv
// Channel  | Direction | Beat contents
// s_*      | in        | tdata: rx_byte[7:0]; tuser: action[0]
// m_*      | out       | tdata: one result item, packed fields (see port)
// APB      | in/out    | sync_first 0x0, sync_second 0x4, ack_class 0x8, ack_positive_id 0xC
//
// One byte beat per clock unless m_* stalls: parser state and output register both
// load at the edge that accepts the beat, so its result shows on m_* in the next cycle.
// Throughput is set by the single byte-wise parse step; there is no other loop.
// Reset (synchronous, i_rst_n low) returns the parser to the sync hunt, clears
// both counters and loads the register defaults. No clearing pass is needed.
// A stall on m_* holds the result; s_tready drops only while the output
// register is full and not being taken.
module ubx_frame_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ubxfr_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] rx_byte
    input  logic [0:0]                    s_tuser,  // [0] action
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] byte_ok, [1] payload_valid, [9:2] payload_byte,
    // [25:10] payload_offset, [26] frame_done, [34:27] msg_class,
    // [42:35] msg_id, [58:43] payload_length, [59] ack_seen,
    // [60] ack_positive, [68:61] pending_sends, [100:69] error_count,
    // [103:101] zero
    output logic [ubxfr_pkg::M_TDATA_W-1:0] m_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ubxfr_pkg::PADDR_W-1:0] paddr,
    input  logic [ubxfr_pkg::PDATA_W-1:0] pwdata,
    output logic [ubxfr_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import ubxfr_pkg::*;

    t_cfg    cfg;
    t_result step_res;
    t_result out_res;
    logic    accept;
    logic    out_free;

    // take a beat whenever the output register can take its result
    assign s_tready = out_free;
    assign accept   = s_tvalid && s_tready;

    ubxfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ubxfr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (s_tuser[0]),
        .i_byte   (s_tdata[7:0]),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    ubxfr_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (step_res),
        .i_ready  (m_tready),
        .o_valid  (m_tvalid),
        .o_free   (out_free),
        .o_result (out_res)
    );

    // pack the result, first field in the low bits
    assign m_tdata = {3'b000,
                      out_res.error_count,
                      out_res.pending_sends,
                      out_res.ack_positive,
                      out_res.ack_seen,
                      out_res.payload_length,
                      out_res.msg_id,
                      out_res.msg_class,
                      out_res.frame_done,
                      out_res.payload_offset,
                      out_res.payload_byte,
                      out_res.payload_valid,
                      out_res.byte_ok};

endmodule

### rtl/core/ubxfr_checker.sv
module ubxfr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // the output stage never blocks input while it can drain
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output stage was free");

    // every accepted beat yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted beat produced no result");

    // a byte cannot be both payload and frame end
    a_payload_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[1] && m_tdata[26]))
        else $error("payload and frame_done together");

    // a rejected byte clears the pending-send count
    a_reject_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[68:61] == 8'd0))
        else $error("pending count survived a rejected byte");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

endmodule

bind ubx_frame_receiver ubxfr_checker u_ubxfr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
